// ===== rtl/content_length_frame_extractor_top_defines.svh =====
// Assertion macros shared by the checker.
`ifndef CONTENT_LENGTH_FRAME_EXTRACTOR_TOP_DEFINES_SVH
`define CONTENT_LENGTH_FRAME_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("framer check failed: same-cycle rule");

// Next-cycle implication, checked out of reset.
`define CLFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("framer check failed: next-cycle rule");

`endif

// ===== rtl/clfe_pkg.sv =====
package clfe_pkg;

    typedef enum logic [3:0] {
        PH_LINE_LEAD  = 4'd0,
        PH_NAME       = 4'd1,
        PH_NAME_TRAIL = 4'd2,
        PH_NAME_BAD   = 4'd3,
        PH_VAL_LEAD   = 4'd4,
        PH_VAL_DIGITS = 4'd5,
        PH_VAL_REST   = 4'd6,
        PH_AFTER_CR   = 4'd7,
        PH_BODY       = 4'd8,
        PH_HALT       = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_CR       = 3'd0,
        ERR_NO_COLON = 3'd1,
        ERR_BAD_LEN  = 3'd2,
        ERR_MISSING  = 3'd3,
        ERR_SHORT    = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        FIN_CLEAR = 2'd0,
        FIN_ERROR = 2'd1,
        FIN_EMPTY = 2'd2,
        FIN_BODY  = 2'd3
    } t_fin;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  body_byte;
        logic        frame_last;
        t_err        error_code;
    } t_result;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [3:0] KEY_LEN  = 4'd14;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

endpackage

// ===== rtl/clfe_parse.sv =====
module clfe_parse #(
    parameter int LEN_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_stream_byte,
    input  logic               i_end_of_stream,
    output logic               o_push,
    output clfe_pkg::t_result  o_result
);

    localparam int PW = LEN_BITS + 4;

    clfe_pkg::t_phase      r_phase, n_phase;
    logic [3:0]            r_match_cnt, n_match_cnt;
    logic                  r_line_nonempty, n_line_nonempty;
    logic                  r_line_has_colon, n_line_has_colon;
    logic                  r_is_length_line, n_is_length_line;
    logic                  r_digit_seen, n_digit_seen;
    logic                  r_value_overflow, n_value_overflow;
    logic [LEN_BITS-1:0]   r_line_value, n_line_value;
    logic                  r_have_length, n_have_length;
    logic [LEN_BITS-1:0]   r_committed_length, n_committed_length;
    logic [LEN_BITS-1:0]   r_body_remaining, n_body_remaining;

    clfe_pkg::t_fin        fin_act;
    clfe_pkg::t_err        fin_err;
    logic                  do_fin;
    logic                  do_new_frame;
    logic                  is_digit;
    logic                  blank;
    logic                  key_hit;
    logic [PW-1:0]         prod;
    logic                  prod_ovf;
    logic                  is_line_phase;

    assign is_digit = (i_stream_byte >= 8'h30) && (i_stream_byte <= 8'h39);
    assign blank    = clfe_pkg::is_blank(i_stream_byte);
    assign key_hit  = (r_match_cnt < clfe_pkg::KEY_LEN) &&
                      (clfe_pkg::to_lower(i_stream_byte) == clfe_pkg::key_char(r_match_cnt));
    assign prod     = ({4'b0, r_line_value} << 3) + ({4'b0, r_line_value} << 1) +
                      PW'(i_stream_byte[3:0]);
    assign prod_ovf = |prod[PW-1:LEN_BITS];
    assign is_line_phase = (r_phase == clfe_pkg::PH_LINE_LEAD) ||
                           (r_phase == clfe_pkg::PH_NAME) ||
                           (r_phase == clfe_pkg::PH_NAME_TRAIL) ||
                           (r_phase == clfe_pkg::PH_NAME_BAD) ||
                           (r_phase == clfe_pkg::PH_VAL_LEAD) ||
                           (r_phase == clfe_pkg::PH_VAL_DIGITS) ||
                           (r_phase == clfe_pkg::PH_VAL_REST);

    // classify the end of the current line
    always_comb begin
        fin_act = clfe_pkg::FIN_CLEAR;
        fin_err = clfe_pkg::ERR_CR;
        if (!r_line_nonempty) begin
            if (!r_have_length) begin
                fin_act = clfe_pkg::FIN_ERROR;
                fin_err = clfe_pkg::ERR_MISSING;
            end else if (r_committed_length == '0) begin
                fin_act = clfe_pkg::FIN_EMPTY;
            end else begin
                fin_act = clfe_pkg::FIN_BODY;
            end
        end else if (!r_line_has_colon) begin
            fin_act = clfe_pkg::FIN_ERROR;
            fin_err = clfe_pkg::ERR_NO_COLON;
        end else if (r_is_length_line && (!r_digit_seen || r_value_overflow)) begin
            fin_act = clfe_pkg::FIN_ERROR;
            fin_err = clfe_pkg::ERR_BAD_LEN;
        end
    end

    // next state
    always_comb begin
        n_phase            = r_phase;
        n_match_cnt        = r_match_cnt;
        n_line_nonempty    = r_line_nonempty;
        n_line_has_colon   = r_line_has_colon;
        n_is_length_line   = r_is_length_line;
        n_digit_seen       = r_digit_seen;
        n_value_overflow   = r_value_overflow;
        n_line_value       = r_line_value;
        n_have_length      = r_have_length;
        n_committed_length = r_committed_length;
        n_body_remaining   = r_body_remaining;
        do_fin             = 1'b0;
        do_new_frame       = 1'b0;

        if (i_accept) begin
            case (r_phase)
                clfe_pkg::PH_HALT: begin
                end
                clfe_pkg::PH_BODY: begin
                    if (i_end_of_stream) begin
                        n_phase = clfe_pkg::PH_HALT;
                    end else begin
                        n_body_remaining = r_body_remaining - LEN_BITS'(1);
                        do_new_frame     = (r_body_remaining == LEN_BITS'(1));
                    end
                end
                clfe_pkg::PH_AFTER_CR: begin
                    if (i_end_of_stream || i_stream_byte != clfe_pkg::CH_LF) begin
                        n_phase = clfe_pkg::PH_HALT;
                    end else begin
                        do_fin = 1'b1;
                    end
                end
                default: begin
                    if (!is_line_phase || i_end_of_stream) begin
                        n_phase = clfe_pkg::PH_HALT;
                    end else if (i_stream_byte == clfe_pkg::CH_CR) begin
                        n_phase = clfe_pkg::PH_AFTER_CR;
                    end else if (i_stream_byte == clfe_pkg::CH_LF) begin
                        do_fin = 1'b1;
                    end else begin
                        n_line_nonempty = 1'b1;
                        case (r_phase)
                            clfe_pkg::PH_LINE_LEAD,
                            clfe_pkg::PH_NAME,
                            clfe_pkg::PH_NAME_TRAIL: begin
                                if (i_stream_byte == clfe_pkg::CH_COLON) begin
                                    n_line_has_colon = 1'b1;
                                    n_is_length_line = (r_phase != clfe_pkg::PH_LINE_LEAD) &&
                                                       (r_match_cnt == clfe_pkg::KEY_LEN);
                                    n_phase          = clfe_pkg::PH_VAL_LEAD;
                                end else if (blank) begin
                                    if (r_phase == clfe_pkg::PH_NAME) begin
                                        n_phase = clfe_pkg::PH_NAME_TRAIL;
                                    end
                                end else if (r_phase != clfe_pkg::PH_NAME_TRAIL && key_hit) begin
                                    n_match_cnt = r_match_cnt + 4'd1;
                                    n_phase     = clfe_pkg::PH_NAME;
                                end else begin
                                    n_phase = clfe_pkg::PH_NAME_BAD;
                                end
                            end
                            clfe_pkg::PH_NAME_BAD: begin
                                if (i_stream_byte == clfe_pkg::CH_COLON) begin
                                    n_line_has_colon = 1'b1;
                                    n_is_length_line = 1'b0;
                                    n_phase          = clfe_pkg::PH_VAL_LEAD;
                                end
                            end
                            clfe_pkg::PH_VAL_LEAD: begin
                                if (is_digit) begin
                                    n_digit_seen = 1'b1;
                                    n_line_value = LEN_BITS'(i_stream_byte[3:0]);
                                    n_phase      = clfe_pkg::PH_VAL_DIGITS;
                                end else if (!blank) begin
                                    n_phase = clfe_pkg::PH_VAL_REST;
                                end
                            end
                            clfe_pkg::PH_VAL_DIGITS: begin
                                if (is_digit) begin
                                    if (!r_value_overflow) begin
                                        if (prod_ovf) begin
                                            n_value_overflow = 1'b1;
                                        end else begin
                                            n_line_value = prod[LEN_BITS-1:0];
                                        end
                                    end
                                end else begin
                                    n_phase = clfe_pkg::PH_VAL_REST;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end

        if (do_fin) begin
            case (fin_act)
                clfe_pkg::FIN_ERROR: n_phase = clfe_pkg::PH_HALT;
                clfe_pkg::FIN_EMPTY: do_new_frame = 1'b1;
                clfe_pkg::FIN_BODY: begin
                    n_body_remaining = r_committed_length;
                    n_phase          = clfe_pkg::PH_BODY;
                end
                default: begin
                    if (r_is_length_line) begin
                        n_committed_length = r_line_value;
                        n_have_length      = 1'b1;
                    end
                    n_phase          = clfe_pkg::PH_LINE_LEAD;
                    n_match_cnt      = '0;
                    n_line_nonempty  = 1'b0;
                    n_line_has_colon = 1'b0;
                    n_is_length_line = 1'b0;
                    n_digit_seen     = 1'b0;
                    n_value_overflow = 1'b0;
                    n_line_value     = '0;
                end
            endcase
        end

        if (do_new_frame) begin
            n_phase            = clfe_pkg::PH_LINE_LEAD;
            n_match_cnt        = '0;
            n_line_nonempty    = 1'b0;
            n_line_has_colon   = 1'b0;
            n_is_length_line   = 1'b0;
            n_digit_seen       = 1'b0;
            n_value_overflow   = 1'b0;
            n_line_value       = '0;
            n_have_length      = 1'b0;
            n_committed_length = '0;
            n_body_remaining   = '0;
        end
    end

    // result word
    always_comb begin
        o_push              = 1'b0;
        o_result.kind       = clfe_pkg::KIND_BODY;
        o_result.body_byte  = 8'h00;
        o_result.frame_last = 1'b0;
        o_result.error_code = clfe_pkg::ERR_CR;

        if (i_accept) begin
            case (r_phase)
                clfe_pkg::PH_HALT: begin
                end
                clfe_pkg::PH_BODY: begin
                    o_push = 1'b1;
                    if (i_end_of_stream) begin
                        o_result.kind       = clfe_pkg::KIND_ERROR;
                        o_result.error_code = clfe_pkg::ERR_SHORT;
                    end else begin
                        o_result.body_byte  = i_stream_byte;
                        o_result.frame_last = (r_body_remaining == LEN_BITS'(1));
                    end
                end
                clfe_pkg::PH_AFTER_CR: begin
                    if (i_end_of_stream || i_stream_byte != clfe_pkg::CH_LF) begin
                        o_push        = 1'b1;
                        o_result.kind = clfe_pkg::KIND_ERROR;
                    end else if (fin_act == clfe_pkg::FIN_ERROR) begin
                        o_push              = 1'b1;
                        o_result.kind       = clfe_pkg::KIND_ERROR;
                        o_result.error_code = fin_err;
                    end else if (fin_act == clfe_pkg::FIN_EMPTY) begin
                        o_push        = 1'b1;
                        o_result.kind = clfe_pkg::KIND_EMPTY;
                    end
                end
                default: begin
                    if (is_line_phase && i_end_of_stream) begin
                        o_push = 1'b1;
                        if (r_line_nonempty && fin_act == clfe_pkg::FIN_ERROR) begin
                            o_result.kind       = clfe_pkg::KIND_ERROR;
                            o_result.error_code = fin_err;
                        end else begin
                            o_result.kind = clfe_pkg::KIND_END;
                        end
                    end else if (is_line_phase && i_stream_byte == clfe_pkg::CH_LF) begin
                        if (fin_act == clfe_pkg::FIN_ERROR) begin
                            o_push              = 1'b1;
                            o_result.kind       = clfe_pkg::KIND_ERROR;
                            o_result.error_code = fin_err;
                        end else if (fin_act == clfe_pkg::FIN_EMPTY) begin
                            o_push        = 1'b1;
                            o_result.kind = clfe_pkg::KIND_EMPTY;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= clfe_pkg::PH_LINE_LEAD;
            r_match_cnt        <= '0;
            r_line_nonempty    <= 1'b0;
            r_line_has_colon   <= 1'b0;
            r_is_length_line   <= 1'b0;
            r_digit_seen       <= 1'b0;
            r_value_overflow   <= 1'b0;
            r_line_value       <= '0;
            r_have_length      <= 1'b0;
            r_committed_length <= '0;
            r_body_remaining   <= '0;
        end else begin
            r_phase            <= n_phase;
            r_match_cnt        <= n_match_cnt;
            r_line_nonempty    <= n_line_nonempty;
            r_line_has_colon   <= n_line_has_colon;
            r_is_length_line   <= n_is_length_line;
            r_digit_seen       <= n_digit_seen;
            r_value_overflow   <= n_value_overflow;
            r_line_value       <= n_line_value;
            r_have_length      <= n_have_length;
            r_committed_length <= n_committed_length;
            r_body_remaining   <= n_body_remaining;
        end
    end

endmodule

// ===== rtl/clfe_queue.sv =====
module clfe_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  clfe_pkg::t_result  i_data,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output clfe_pkg::t_result  o_data
);

    clfe_pkg::t_result                 r_mem [clfe_pkg::QUEUE_DEPTH];
    logic [clfe_pkg::QUEUE_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [clfe_pkg::QUEUE_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [clfe_pkg::QUEUE_PTR_W:0]    r_count, n_count;
    logic                              push_ok;
    logic                              pop_ok;

    assign o_full  = (r_count == (clfe_pkg::QUEUE_PTR_W + 1)'(clfe_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/content_length_frame_extractor_top.sv =====
// Each result word is registered in the result queue before it is offered.
// Throughput: one input word per cycle while o_stall is low (result queue not full).
// A four-entry result queue lets the parser keep accepting while the output is stalled.
// Reset (synchronous, active low): parser waits at the start of a header line, queue empty.
module content_length_frame_extractor_top #(
    parameter int LEN_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_body_byte,
    output logic        o_frame_last,
    output logic [2:0]  o_error_code
);

    logic               in_accept;
    logic               push;
    logic               full;
    clfe_pkg::t_result  push_data;
    clfe_pkg::t_result  head;

    assign o_stall   = full;
    assign in_accept = i_valid && !full;

    clfe_parse #(
        .LEN_BITS (LEN_BITS)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_stream_byte   (i_stream_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_push          (push),
        .o_result        (push_data)
    );

    clfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (!i_stall),
        .o_full  (full),
        .o_valid (o_valid),
        .o_data  (head)
    );

    assign o_kind       = head.kind;
    assign o_body_byte  = head.body_byte;
    assign o_frame_last = head.frame_last;
    assign o_error_code = head.error_code;

endmodule

// ===== rtl/clfe_check.sv =====
`include "content_length_frame_extractor_top_defines.svh"

module clfe_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_body_byte,
    input logic        o_frame_last,
    input logic [2:0]  o_error_code
);

    logic        out_take;
    logic        out_wait;
    logic        out_final;
    logic [13:0] out_word;

    assign out_take  = o_valid && !i_stall;
    assign out_wait  = o_valid && i_stall;
    assign out_final = (o_kind == clfe_pkg::KIND_ERROR) || (o_kind == clfe_pkg::KIND_END);
    assign out_word  = {o_kind, o_body_byte, o_frame_last, o_error_code};

    `CLFE_ASSERT_NEXT(a_halt_last, i_clk, i_rst_n, out_take && out_final, !o_valid)
    `CLFE_ASSERT_NEXT(a_hold_word, i_clk, i_rst_n, out_wait, o_valid && $stable(out_word))
    `CLFE_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_stall, o_valid)
    `CLFE_ASSERT_NOW(a_last_body, i_clk, i_rst_n, o_valid && o_frame_last, o_kind == clfe_pkg::KIND_BODY)

endmodule

bind content_length_frame_extractor_top clfe_check u_clfe_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_body_byte  (o_body_byte),
    .o_frame_last (o_frame_last),
    .o_error_code (o_error_code)
);
